// ===== src/htrp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the digit decoder of the hex telemetry record parser.
// Used by htrp_engine and hex_telemetry_record_parser; no dependencies.
package htrp_pkg;

    localparam int DIGITS_PER_RECORD = 4;
    localparam int CNT_W             = 3;
    localparam int NUM_KINDS         = 3;
    localparam int KIND_W            = 2;
    localparam int VALUE_W           = 16;

    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] TAG_HEADING  = 8'h48;
    localparam logic [7:0] TAG_VELOCITY = 8'h56;
    localparam logic [7:0] TAG_DISTANCE = 8'h53;

    localparam logic [KIND_W-1:0] KIND_HEADING  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VELOCITY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DISTANCE = 2'd2;

    localparam logic [CNT_W-1:0] DIGITS_DONE = CNT_W'(DIGITS_PER_RECORD);

    typedef struct packed {
        logic                      hit;
        logic [KIND_W-1:0]         kind;
        logic signed [VALUE_W-1:0] value;
    } htrp_result_t;

    // Tag byte that starts each record kind.
    function automatic logic [7:0] tag_byte(input logic [KIND_W-1:0] kind);
        logic [7:0] t;
        begin
            case (kind)
                KIND_HEADING:  t = TAG_HEADING;
                KIND_VELOCITY: t = TAG_VELOCITY;
                default:       t = TAG_DISTANCE;
            endcase
            return t;
        end
    endfunction

    // '0'-'9' -> 0..9, 'A'-'F' -> 10..15, anything else sign-extended as is.
    function automatic logic [VALUE_W-1:0] digit_value(input logic [7:0] b);
        logic [VALUE_W-1:0] v;
        begin
            if (b >= 8'd48 && b <= 8'd57)
                v = {8'h00, b - 8'd48};
            else if (b >= 8'd65 && b <= 8'd70)
                v = {8'h00, b - 8'd55};
            else
                v = {{8{b[7]}}, b};
            return v;
        end
    endfunction

endpackage

// ===== src/htrp_engine.sv =====
`timescale 1ns / 1ps
// Record state of the parser: tag arming, per-record accumulators and digit counts.
// Depends on htrp_pkg.
module htrp_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  logic [7:0]            rx_byte,
    output htrp_pkg::htrp_result_t result
);
    import htrp_pkg::*;

    logic                    armed_reg;
    logic                    armed_next;
    logic [NUM_KINDS-1:0]    active_reg;
    logic [NUM_KINDS-1:0]    active_next;
    logic [CNT_W-1:0]        digits_reg [NUM_KINDS];
    logic [CNT_W-1:0]        digits_next [NUM_KINDS];
    logic [VALUE_W-1:0]      accum_reg [NUM_KINDS];
    logic [VALUE_W-1:0]      accum_next [NUM_KINDS];

    logic                    is_lf;
    logic [NUM_KINDS-1:0]    tag_hit;
    logic                    sel_valid;
    logic [KIND_W-1:0]       sel;
    logic [VALUE_W-1:0]      sel_acc;
    logic [CNT_W-1:0]        sel_cnt;
    logic                    done;

    assign is_lf = (rx_byte == BYTE_LF);

    always_comb
    begin
        for (int k = 0; k < NUM_KINDS; k++)
        begin
            tag_hit[k] = armed_reg && (rx_byte == tag_byte(KIND_W'(k)));
        end
    end

    // first active record in priority order takes the digit
    always_comb
    begin
        sel_valid = 1'b0;
        sel       = KIND_HEADING;
        for (int k = NUM_KINDS - 1; k >= 0; k--)
        begin
            if (active_reg[k])
            begin
                sel_valid = 1'b1;
                sel       = KIND_W'(k);
            end
        end
        if (is_lf || (|tag_hit))
            sel_valid = 1'b0;
    end

    assign sel_acc = {accum_reg[sel][VALUE_W-5:0], 4'h0} | digit_value(rx_byte);
    assign sel_cnt = digits_reg[sel] + CNT_W'(1);
    assign done    = sel_valid && (sel_cnt == DIGITS_DONE);

    assign result.hit   = take && done;
    assign result.kind  = sel;
    assign result.value = sel_acc;

    always_comb
    begin
        armed_next  = armed_reg;
        active_next = active_reg;
        digits_next = digits_reg;
        accum_next  = accum_reg;
        if (take)
        begin
            if (is_lf)
            begin
                armed_next = 1'b1;
            end
            else if (|tag_hit)
            begin
                armed_next = 1'b0;
                for (int k = 0; k < NUM_KINDS; k++)
                begin
                    if (tag_hit[k])
                    begin
                        active_next[k] = 1'b1;
                        digits_next[k] = '0;
                    end
                end
            end
            else if (sel_valid)
            begin
                if (done)
                begin
                    active_next[sel] = 1'b0;
                    digits_next[sel] = '0;
                    accum_next[sel]  = '0;
                end
                else
                begin
                    digits_next[sel] = sel_cnt;
                    accum_next[sel]  = sel_acc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b0;
            active_reg <= '0;
            for (int k = 0; k < NUM_KINDS; k++)
            begin
                digits_reg[k] <= '0;
                accum_reg[k]  <= '0;
            end
        end
        else
        begin
            armed_reg  <= armed_next;
            active_reg <= active_next;
            digits_reg <= digits_next;
            accum_reg  <= accum_next;
        end
    end

endmodule

// ===== src/hex_telemetry_record_parser.sv =====
`timescale 1ns / 1ps
// Top level of the hex telemetry record parser: record engine plus output buffer.
// Depends on htrp_pkg and htrp_engine.

// Accepts one ASCII word per clock while in_stall is low and registers a completed
// record (kind and 16-bit value) from the word that supplied its last hex digit.
// A line feed arms the tag detector; an armed 'H', 'V' or 'S' opens a heading,
// velocity or distance record. Record state updates in the same cycle as the
// word is taken, so a word enters every cycle; the only thing that holds off
// input is a full two-word output buffer (result register plus skid entry),
// i.e. in_stall rises only after two results are waiting on a stalled output.
// Lower-case hex is not decoded; other bytes are ORed in sign-extended, and
// distance values are raw tenths for the consumer to scale.
module hex_telemetry_record_parser (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          rx_byte,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [htrp_pkg::KIND_W-1:0]         record_kind,
    output logic signed [htrp_pkg::VALUE_W-1:0] record_value
);
    import htrp_pkg::*;

    htrp_result_t res;
    logic         in_take;
    logic         out_pop;

    // output register and skid entry
    logic                      out_valid_reg;
    logic [KIND_W-1:0]         out_kind_reg;
    logic signed [VALUE_W-1:0] out_value_reg;
    logic                      skid_valid_reg;
    logic [KIND_W-1:0]         skid_kind_reg;
    logic signed [VALUE_W-1:0] skid_value_reg;

    assign in_stall = skid_valid_reg;
    assign in_take  = in_valid && !in_stall;
    assign out_pop  = out_valid_reg && !out_stall;

    htrp_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (in_take),
        .rx_byte (rx_byte),
        .result  (res)
    );

    // control: skid holds a result only while the output register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_pop)
                skid_valid_reg <= 1'b0;
        end
        else if (res.hit)
        begin
            if (out_valid_reg && !out_pop)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_pop)
            begin
                out_kind_reg  <= skid_kind_reg;
                out_value_reg <= skid_value_reg;
            end
        end
        else if (res.hit)
        begin
            if (out_valid_reg && !out_pop)
            begin
                skid_kind_reg  <= res.kind;
                skid_value_reg <= res.value;
            end
            else
            begin
                out_kind_reg  <= res.kind;
                out_value_reg <= res.value;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign record_kind  = out_kind_reg;
    assign record_value = out_value_reg;

`ifndef SYNTHESIS
    // skid entry is only used behind a held output word
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // a result is only produced from a word actually taken
    a_hit_needs_take: assert property (@(posedge clk) disable iff (!rst_n)
        res.hit |-> in_take)
        else $error("record completed without an accepted word");

    // a line feed never completes a record
    a_lf_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_take && rx_byte == BYTE_LF) |-> !res.hit)
        else $error("line feed completed a record");

    // new result lands in output register when it is free
    a_result_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (res.hit && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("result not loaded into free output register");
`endif

endmodule

// ===== test/tb_hex_telemetry_record_parser.sv =====
`timescale 1ns / 1ps
// Testbench for hex_telemetry_record_parser: feeds ASCII words, tracks records, checks output.
// Depends on htrp_pkg and the parser RTL; needs no other files.
module tb_hex_telemetry_record_parser;
    import htrp_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [7:0]                rx_byte;
    logic                      out_valid;
    logic                      out_stall;
    logic [KIND_W-1:0]         record_kind;
    logic signed [VALUE_W-1:0] record_value;

    hex_telemetry_record_parser dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .record_kind  (record_kind),
        .record_value (record_value)
    );

    // Tracker copy of the parser state
    logic               tag_armed;
    logic [2:0]         rec_open;
    logic [CNT_W-1:0]   rec_count [0:2];
    logic [VALUE_W-1:0] rec_accum [0:2];

    // Records still owed by the block, oldest first
    logic [KIND_W-1:0]  owed_kind [$];
    logic [VALUE_W-1:0] owed_value [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int words_sent     = 0;
    int records_seen   = 0;
    int mismatches     = 0;
    int kind_seen [0:3];

    logic [KIND_W-1:0]  got_kind_exp;
    logic [VALUE_W-1:0] got_value_exp;

    // Corner words: every digit class edge, sign extension, lower case, LF mid-record,
    // unarmed tag, two records open at once and a heading restart.
    logic [7:0] corner_words [0:26] = '{
        BYTE_LF, TAG_HEADING, 8'h30, 8'h39, 8'h41, 8'h46,
        BYTE_LF, TAG_VELOCITY, 8'hFF, 8'h61,
        BYTE_LF, TAG_DISTANCE,
        8'h00, 8'h7F,
        TAG_HEADING, 8'h2F, 8'h3A, 8'h40,
        BYTE_LF, TAG_HEADING, 8'h47, BYTE_LF, TAG_HEADING, 8'h80, 8'h45, 8'h39, 8'h41
    };

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // ---------------- tracker ----------------

    function automatic logic [VALUE_W-1:0] digit_bits(input logic [7:0] b);
        if (b >= 8'h30 && b <= 8'h39)
            return {8'h00, b - 8'h30};
        if (b >= 8'h41 && b <= 8'h46)
            return {8'h00, b - 8'h37};
        return {{8{b[7]}}, b};
    endfunction

    function automatic int kind_of_tag(input logic [7:0] b);
        case (b)
            TAG_HEADING:  return KIND_HEADING;
            TAG_VELOCITY: return KIND_VELOCITY;
            TAG_DISTANCE: return KIND_DISTANCE;
            default:      return -1;
        endcase
    endfunction

    function automatic void clear_tracker();
        int k;
        tag_armed = 1'b0;
        rec_open  = '0;
        for (k = 0; k < NUM_KINDS; k++)
        begin
            rec_count[k] = '0;
            rec_accum[k] = '0;
        end
    endfunction

    function automatic void track_word(input logic [7:0] b);
        int k;
        int taker;
        int tag;
        int done;
        taker = -1;
        done  = 0;
        tag   = kind_of_tag(b);
        if (b == BYTE_LF)
            tag_armed = 1'b1;
        else if (tag_armed && tag >= 0)
        begin
            // restart keeps the accumulator, only the count clears
            rec_open[tag]  = 1'b1;
            rec_count[tag] = '0;
            tag_armed      = 1'b0;
            return;
        end
        else
        begin
            for (k = NUM_KINDS - 1; k >= 0; k--)
                if (rec_open[k])
                    taker = k;
            if (taker >= 0)
            begin
                rec_accum[taker] = (rec_accum[taker] << 4) | digit_bits(b);
                rec_count[taker] = rec_count[taker] + 1'b1;
            end
        end
        for (k = 0; k < NUM_KINDS; k++)
            if (done == 0 && rec_count[k] == DIGITS_PER_RECORD)
            begin
                owed_kind.push_back(k[KIND_W-1:0]);
                owed_value.push_back(rec_accum[k]);
                rec_open[k]  = 1'b0;
                rec_count[k] = '0;
                rec_accum[k] = '0;
                done = 1;
            end
    endfunction

    // ---------------- stimulus helpers ----------------

    function automatic logic [7:0] pick_tag();
        case ($urandom_range(2))
            0:       return TAG_HEADING;
            1:       return TAG_VELOCITY;
            default: return TAG_DISTANCE;
        endcase
    endfunction

    // Mostly upper-case hex, some LF, the rest any byte
    function automatic logic [7:0] pick_digit();
        int r;
        int n;
        logic [7:0] v;
        r = $urandom_range(99);
        n = $urandom_range(15);
        v = 8'($urandom_range(255));
        if (r < 65)
            return (n < 10) ? 8'(8'h30 + n) : 8'(8'h37 + n);
        if (r < 70)
            return BYTE_LF;
        return v;
    endfunction

    task automatic send_word(input logic [7:0] b);
        logic held;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do
        begin
            @(negedge clk);
            held = in_stall;
            @(posedge clk);
        end while (held);
        track_word(b);
        words_sent++;
    endtask

    task automatic send_record(input int n_digits);
        send_word(BYTE_LF);
        send_word(pick_tag());
        repeat (n_digits) send_word(pick_digit());
    endtask

    task automatic send_random_traffic(input int n_words);
        int stop_at;
        int r;
        stop_at = words_sent + n_words;
        while (words_sent < stop_at)
        begin
            r = $urandom_range(99);
            if (r < 72)
                send_record(DIGITS_PER_RECORD);
            else if (r < 82)
                send_record($urandom_range(DIGITS_PER_RECORD - 1)); // left open
            else if (r < 90)
            begin
                send_word(BYTE_LF);
                send_word(BYTE_LF);
                send_word(pick_tag());
            end
            else if (r < 95)
                send_word(pick_tag());                              // often unarmed
            else
                repeat ($urandom_range(1, 4)) send_word(8'($urandom_range(255)));
        end
    endtask

    task automatic wait_drained();
        while (owed_kind.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // ---------------- tests ----------------

    task automatic test_corner_words();
        int i;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (i = 0; i < 27; i++)
            send_word(corner_words[i]);
    endtask

    task automatic test_random_mix(input int send_pct, input int recv_pct, input int n_words);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        send_random_traffic(n_words);
    endtask

    // Output held off long enough for the two-entry buffer to fill and push back
    task automatic test_output_holdoff();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 300;
        repeat (40) send_record(DIGITS_PER_RECORD);
    endtask

    // ---------------- receiver side ----------------

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // out_stall and outputs are stable from the rising edge on, so the
    // falling edge sees what the next rising edge will accept
    always @(negedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (owed_kind.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected record: kind %0d value %h", record_kind, record_value);
            end
            else
            begin
                got_kind_exp  = owed_kind.pop_front();
                got_value_exp = owed_value.pop_front();
                records_seen++;
                kind_seen[got_kind_exp]++;
                if (record_kind !== got_kind_exp || record_value !== got_value_exp)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("record %0d: expected kind %0d value %h, got kind %0d value %h",
                                 records_seen, got_kind_exp, got_value_exp,
                                 record_kind, record_value);
                end
            end
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        rst_n    = 1'b0;
        in_valid = 1'b0;
        rx_byte  = '0;
        kind_seen = '{0, 0, 0, 0};
        clear_tracker();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_corner_words();
        test_random_mix(0, 0, 360);
        test_random_mix(82, 0, 360);
        test_random_mix(0, 82, 360);
        test_random_mix(35, 35, 360);
        test_output_holdoff();
        in_valid <= 1'b0;
        wait_drained();

        $display("covered %0d words and %0d records (heading %0d, velocity %0d, distance %0d)",
                 words_sent, records_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("under no gaps, sender gaps, receiver stalls, both, and a 300-cycle hold");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
